// ===== src/address_region_table_defines.svh =====
// Assertion macros for the address region table checker.
`ifndef ADDRESS_REGION_TABLE_DEFINES_SVH
`define ADDRESS_REGION_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ART_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("address_region_table: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ART_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("address_region_table: next-cycle check failed");

`endif

// ===== src/art_pkg.sv =====
// Package: sizes, command and status codes, and the table entry type.
`timescale 1ns / 1ps

package art_pkg;

  // Table geometry and address arithmetic
  localparam int NUM_REGIONS = 16;
  localparam int PAGE_SHIFT  = 12;
  localparam int ADDR_BITS   = 48;

  // Fixed field widths of the stream items
  localparam int CMD_W        = 3;
  localparam int TYPE_W       = 16;
  localparam int FIELD_ADDR_W = 48;
  localparam int PAGE_W       = 32;
  localparam int STATUS_W     = 3;

  localparam int IDX_W   = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int CNT_W   = $clog2(NUM_REGIONS + 1);
  localparam int DELTA_W = PAGE_W + PAGE_SHIFT;
  localparam int SUM_W   = ((ADDR_BITS > DELTA_W) ? ADDR_BITS : DELTA_W) + 1;

  // Input item layout, lowest field first
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_TYPE_LSB  = IN_CMD_LSB + CMD_W;
  localparam int IN_START_LSB = IN_TYPE_LSB + TYPE_W;
  localparam int IN_END_LSB   = IN_START_LSB + FIELD_ADDR_W;
  localparam int IN_PAGE_LSB  = IN_END_LSB + FIELD_ADDR_W;
  localparam int IN_W         = IN_PAGE_LSB + PAGE_W;
  localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;

  // Output item layout, lowest field first
  localparam int OUT_W       = STATUS_W + 2 * FIELD_ADDR_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND_FIRST   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_LAST    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EXT_END      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EXT_START    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SHRINK_END   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SHRINK_START = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SHRUNK    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [TYPE_W-1:0]    rtype;
    logic [ADDR_BITS-1:0] start_addr;
    logic [ADDR_BITS-1:0] end_addr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/art_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/address_region_table.sv =====
// Top level: sorted address region table with a small command sequencer.
`timescale 1ns / 1ps

// Address region table.
// Input channel s_*: one command item (insert, remove, find first/last,
// extend or shrink an edge by whole pages). Output channel m_*: one result
// item per command (status, region start, region end).
// Entries live in one RAM (one write, one registered read per cycle) and the
// count register marks how many are valid. A sequencer walks the RAM:
// scanning an entry is a read state then a check state, moving one entry on
// insert or remove is a read state then a write state, and an edge move uses
// one shared add/subtract unit, then a range check and a write-back. Find
// last and a search that misses walk all entries; insert walks to its slot,
// then moves every entry above it up one slot; remove moves every entry
// above the region down one slot. An insert into a full table goes straight
// to the result with a full status. The sequencer returns to idle after
// each command and takes the next from there, and one command is worked on at a
// time. The result sits in an output register, so the next command is taken
// while it waits; a stalled m_tready holds the result and the sequencer
// waits before posting the next one.
// Reset empties the table at once (count to zero) and drops any result.
module address_region_table
  import art_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // command, region_type, region_start, region_end, page_count (lowest first)
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status, found_start, found_end (lowest first)
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_END   = 4'd3;
  localparam logic [3:0] S_FOUND = 4'd4;
  localparam logic [3:0] S_NCAP  = 4'd5;
  localparam logic [3:0] S_ARITH = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_IRD   = 4'd9;
  localparam logic [3:0] S_IWR   = 4'd10;
  localparam logic [3:0] S_INEW  = 4'd11;
  localparam logic [3:0] S_RRD   = 4'd12;
  localparam logic [3:0] S_RWR   = 4'd13;
  localparam logic [3:0] S_RESP  = 4'd14;

  logic [3:0] state;

  // Unpacked input fields
  logic [CMD_W-1:0]        in_cmd;
  logic [TYPE_W-1:0]       in_type;
  logic [FIELD_ADDR_W-1:0] in_start;
  logic [FIELD_ADDR_W-1:0] in_end;
  logic [PAGE_W-1:0]       in_page;

  // Command registers
  logic [CMD_W-1:0]     cmd;
  logic [TYPE_W-1:0]    typ;
  logic [ADDR_BITS-1:0] rs;
  logic [ADDR_BITS-1:0] re;
  logic [DELTA_W-1:0]   delta;

  // Table and walk registers
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     k;
  logic                 hit;
  logic                 has_nbr;
  logic [ADDR_BITS-1:0] nbr;
  logic [ADDR_BITS-1:0] s;
  logic [ADDR_BITS-1:0] e;
  logic [SUM_W-1:0]     acc;
  logic [STATUS_W-1:0]  status;

  // Output register
  logic [STATUS_W-1:0]     out_status;
  logic [FIELD_ADDR_W-1:0] out_start;
  logic [FIELD_ADDR_W-1:0] out_end;

  // RAM port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd;
  logic [CNT_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   wr_ptr;

  // Helpers
  logic [CNT_W-1:0]     idx_inc;
  logic [CNT_W-1:0]     idx_dec;
  logic [CNT_W-1:0]     k_inc;
  logic                 type_hit;
  logic                 add_op;
  logic [ADDR_BITS-1:0] base;
  logic [SUM_W-1:0]     sum_out;
  logic                 out_range;
  logic [ADDR_BITS-1:0] acc_a;

  assign in_cmd   = s_tdata[IN_CMD_LSB +: CMD_W];
  assign in_type  = s_tdata[IN_TYPE_LSB +: TYPE_W];
  assign in_start = s_tdata[IN_START_LSB +: FIELD_ADDR_W];
  assign in_end   = s_tdata[IN_END_LSB +: FIELD_ADDR_W];
  assign in_page  = s_tdata[IN_PAGE_LSB +: PAGE_W];

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_end, out_start, out_status};

  assign idx_inc  = idx + CNT_W'(1);
  assign idx_dec  = idx - CNT_W'(1);
  assign k_inc    = k + CNT_W'(1);
  assign rd       = entry_t'(ram_rdata);
  assign type_hit = (rd.rtype == typ);

  // Shared add/subtract unit for edge moves
  assign add_op    = (cmd == CMD_EXT_END) || (cmd == CMD_SHRINK_START);
  assign base      = ((cmd == CMD_EXT_END) || (cmd == CMD_SHRINK_END)) ? e : s;
  assign sum_out   = add_op ? (SUM_W'(base) + SUM_W'(delta))
                            : (SUM_W'(base) - SUM_W'(delta));
  // Past the address range, or below zero (borrow sets the top bit)
  assign out_range = |acc[SUM_W-1:ADDR_BITS];
  assign acc_a     = acc[ADDR_BITS-1:0];

  // Pick RAM read and write addresses per state
  always_comb begin
    ram_we    = 1'b0;
    wr_ptr    = idx;
    ram_wdata = rd;
    unique case (state)
      S_FOUND: rd_ptr = k_inc;
      S_IRD:   rd_ptr = idx_dec;
      S_RRD:   rd_ptr = idx_inc;
      default: rd_ptr = idx;
    endcase
    unique case (state) inside
      S_IWR, S_RWR: begin
        ram_we = 1'b1;
      end
      S_INEW: begin
        ram_we    = 1'b1;
        wr_ptr    = k;
        ram_wdata = '{rtype: typ, start_addr: rs, end_addr: re};
      end
      S_WB: begin
        ram_we    = 1'b1;
        wr_ptr    = k;
        ram_wdata = '{rtype: typ, start_addr: s, end_addr: e};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = rd_ptr[IDX_W-1:0];
  assign ram_waddr = wr_ptr[IDX_W-1:0];

  art_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_REGIONS)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        // Take a command and start the walk at entry 0 (full-table insert: straight to result)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd     <= in_cmd;
            typ     <= in_type;
            rs      <= ADDR_BITS'(in_start);
            re      <= ADDR_BITS'(in_end);
            delta   <= {in_page, {PAGE_SHIFT{1'b0}}};
            idx     <= '0;
            hit     <= 1'b0;
            has_nbr <= 1'b0;
            nbr     <= '0;
            if (in_cmd == CMD_INSERT) begin
              s <= ADDR_BITS'(in_start);
              e <= ADDR_BITS'(in_end);
              if (count == CNT_W'(NUM_REGIONS)) begin
                status <= ST_FULL;
                state  <= S_RESP;
              end else begin
                status <= ST_OK;
                state  <= S_RD;
              end
            end else begin
              s      <= '0;
              e      <= '0;
              status <= ST_OK;
              state  <= S_RD;
            end
          end
        end
        // Issue a read of entry idx, or stop at the tail
        S_RD: begin
          state <= (idx == count) ? S_END : S_CHK;
        end
        // Examine the entry just read
        S_CHK: begin
          if (cmd == CMD_INSERT) begin
            if (rd.start_addr >= re) begin
              k     <= idx;
              idx   <= count;
              state <= S_IRD;
            end else begin
              idx   <= idx_inc;
              state <= S_RD;
            end
          end else if (cmd == CMD_FIND_LAST) begin
            if (type_hit) begin
              hit <= 1'b1;
              k   <= idx;
              s   <= rd.start_addr;
              e   <= rd.end_addr;
            end
            idx   <= idx_inc;
            state <= S_RD;
          end else if (type_hit) begin
            k       <= idx;
            s       <= rd.start_addr;
            e       <= rd.end_addr;
            has_nbr <= (idx != '0);
            state   <= S_FOUND;
          end else begin
            nbr   <= rd.end_addr;
            idx   <= idx_inc;
            state <= S_RD;
          end
        end
        // Walk ran off the tail
        S_END: begin
          if (cmd == CMD_INSERT) begin
            k     <= count;
            idx   <= count;
            state <= S_IRD;
          end else begin
            if (!hit) begin
              status <= ST_NOT_FOUND;
            end
            state <= S_RESP;
          end
        end
        // Dispatch on the region found at k
        S_FOUND: begin
          unique case (cmd) inside
            CMD_FIND_FIRST: begin
              state <= S_RESP;
            end
            CMD_REMOVE: begin
              idx   <= k;
              state <= S_RRD;
            end
            CMD_EXT_END: begin
              if (k_inc < count) begin
                has_nbr <= 1'b1;
                state   <= S_NCAP;
              end else begin
                has_nbr <= 1'b0;
                state   <= S_ARITH;
              end
            end
            CMD_EXT_START, CMD_SHRINK_END, CMD_SHRINK_START: begin
              state <= S_ARITH;
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        // Hold the next entry's start
        S_NCAP: begin
          nbr   <= rd.start_addr;
          state <= S_ARITH;
        end
        // Move the edge in the shared unit
        S_ARITH: begin
          acc   <= sum_out;
          state <= S_CHECK;
        end
        // Check range, neighbor and other edge
        S_CHECK: begin
          if (out_range) begin
            status <= ST_NO_ROOM;
            state  <= S_RESP;
          end else begin
            unique case (cmd) inside
              CMD_EXT_END: begin
                if (has_nbr && (acc_a > nbr)) begin
                  status <= ST_NO_ROOM;
                  state  <= S_RESP;
                end else begin
                  e     <= acc_a;
                  state <= S_WB;
                end
              end
              CMD_EXT_START: begin
                if (has_nbr && (nbr > acc_a)) begin
                  status <= ST_NO_ROOM;
                  state  <= S_RESP;
                end else begin
                  s     <= acc_a;
                  state <= S_WB;
                end
              end
              CMD_SHRINK_END: begin
                if (acc_a < s) begin
                  status <= ST_SHRUNK;
                  state  <= S_RESP;
                end else begin
                  e     <= acc_a;
                  state <= S_WB;
                end
              end
              default: begin
                if (acc_a > e) begin
                  status <= ST_SHRUNK;
                  state  <= S_RESP;
                end else begin
                  s     <= acc_a;
                  state <= S_WB;
                end
              end
            endcase
          end
        end
        // Write the moved region back
        S_WB: begin
          state <= S_RESP;
        end
        // Insert: move entries up one slot from the tail down to k
        S_IRD: begin
          state <= (idx == k) ? S_INEW : S_IWR;
        end
        S_IWR: begin
          idx   <= idx_dec;
          state <= S_IRD;
        end
        S_INEW: begin
          count <= count + CNT_W'(1);
          state <= S_RESP;
        end
        // Remove: move entries down one slot from k to the tail
        S_RRD: begin
          if (idx_inc == count) begin
            count <= count - CNT_W'(1);
            state <= S_RESP;
          end else begin
            state <= S_RWR;
          end
        end
        S_RWR: begin
          idx   <= idx_inc;
          state <= S_RRD;
        end
        // Post the result once the output register is free
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= status;
            out_start  <= FIELD_ADDR_W'(s);
            out_end    <= FIELD_ADDR_W'(e);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/art_checker.sv =====
// Port-level checker for the address region table, bound to the top level.
`timescale 1ns / 1ps
`include "address_region_table_defines.svh"

module art_checker
  import art_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic s_accept;

  assign s_accept = s_tvalid && s_tready;

  // Busy right after taking a command
  `ART_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready)

  // No result appears in the cycle after a command is taken
  `ART_ASSERT_NEXT(a_no_instant_result, s_accept, !$rose(m_tvalid))

  // A new result is posted only while the sequencer was busy
  `ART_ASSERT_NOW(a_result_while_busy, $rose(m_tvalid), !$past(s_tready))

  // Stalled result holds
  `ART_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind address_region_table art_checker u_art_checker (.*);

// ===== tb/tb_address_region_table.sv =====
// Testbench for the address region table: directed and random command streams checked against a table mirror.
`timescale 1ns / 1ps

module tb_address_region_table;
  import art_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int DRAIN_CYCLES  = 100;
  localparam int PRINT_LIMIT   = 40;
  localparam int OUT_START_LSB = STATUS_W;
  localparam int OUT_END_LSB   = STATUS_W + FIELD_ADDR_W;
  localparam logic [FIELD_ADDR_W-1:0] ADDR_TOP = '1;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [TYPE_W-1:0]       rtype;
    logic [FIELD_ADDR_W-1:0] start_addr;
    logic [FIELD_ADDR_W-1:0] end_addr;
    logic [PAGE_W-1:0]       pages;
  } region_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [FIELD_ADDR_W-1:0] found_start;
    logic [FIELD_ADDR_W-1:0] found_end;
  } region_result_t;

  // Mirror of the region table; queues the result each command must produce
  class region_table_mirror;
    logic [TYPE_W-1:0] rtype [NUM_REGIONS];
    logic [63:0]       rstart [NUM_REGIONS];
    logic [63:0]       rend [NUM_REGIONS];
    int                count;
    region_result_t    pending[$];
    int                errors;

    function new();
      for (int i = 0; i < NUM_REGIONS; i++) begin
        rtype[i]  = '0;
        rstart[i] = '0;
        rend[i]   = '0;
      end
      count  = 0;
      errors = 0;
    endfunction

    // Index of the first or last entry with this type, -1 if none
    function int locate(logic [TYPE_W-1:0] t, bit want_last);
      int hit;
      hit = -1;
      for (int i = 0; i < count; i++) begin
        if (rtype[i] == t) begin
          if (!want_last && hit < 0) hit = i;
          if (want_last) hit = i;
        end
      end
      return hit;
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    endfunction

    // Apply one accepted command and note its expected result
    function void apply_command(region_cmd_t c);
      logic [63:0]    amask;
      logic [63:0]    rs;
      logic [63:0]    re;
      logic [63:0]    delta;
      logic [63:0]    s;
      logic [63:0]    e;
      region_result_t r;
      int             k;
      int             pos;
      int             i;
      amask = (64'd1 << ADDR_BITS) - 64'd1;
      rs    = 64'(c.start_addr) & amask;
      re    = 64'(c.end_addr) & amask;
      delta = 64'(c.pages) << PAGE_SHIFT;
      r.status      = ST_OK;
      r.found_start = '0;
      r.found_end   = '0;
      if (c.cmd == CMD_INSERT) begin
        r.found_start = rs[FIELD_ADDR_W-1:0];
        r.found_end   = re[FIELD_ADDR_W-1:0];
        if (count >= NUM_REGIONS) begin
          r.status = ST_FULL;
        end else begin
          // place in front of the first entry starting at or above the new end
          pos = 0;
          while (pos < count && rstart[pos] < re) pos++;
          for (i = count; i > pos; i--) begin
            rtype[i]  = rtype[i-1];
            rstart[i] = rstart[i-1];
            rend[i]   = rend[i-1];
          end
          rtype[pos]  = c.rtype;
          rstart[pos] = rs;
          rend[pos]   = re;
          count++;
        end
      end else begin
        k = locate(c.rtype, c.cmd == CMD_FIND_LAST);
        if (k < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          s = rstart[k];
          e = rend[k];
          case (c.cmd)
            CMD_REMOVE: begin
              for (i = k; i + 1 < count; i++) begin
                rtype[i]  = rtype[i+1];
                rstart[i] = rstart[i+1];
                rend[i]   = rend[i+1];
              end
              count--;
              rtype[count]  = '0;
              rstart[count] = '0;
              rend[count]   = '0;
            end
            CMD_EXT_END: begin
              if (delta > amask - e) r.status = ST_NO_ROOM;
              else if (k + 1 < count && e + delta > rstart[k+1]) r.status = ST_NO_ROOM;
              else e = e + delta;
            end
            CMD_EXT_START: begin
              if (delta > s) r.status = ST_NO_ROOM;
              else if (k > 0 && rend[k-1] > s - delta) r.status = ST_NO_ROOM;
              else s = s - delta;
            end
            CMD_SHRINK_END: begin
              if (delta > e) r.status = ST_NO_ROOM;
              else if (e - delta < s) r.status = ST_SHRUNK;
              else e = e - delta;
            end
            CMD_SHRINK_START: begin
              if (delta > amask - s) r.status = ST_NO_ROOM;
              else if (s + delta > e) r.status = ST_SHRUNK;
              else s = s + delta;
            end
            default: begin
            end
          endcase
          if (c.cmd != CMD_REMOVE) begin
            rstart[k] = s;
            rend[k]   = e;
          end
          r.found_start = s[FIELD_ADDR_W-1:0];
          r.found_end   = e[FIELD_ADDR_W-1:0];
        end
      end
      pending.push_back(r);
    endfunction

    // Compare one result item with the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] word);
      region_result_t want;
      logic [STATUS_W-1:0]     got_status;
      logic [FIELD_ADDR_W-1:0] got_start;
      logic [FIELD_ADDR_W-1:0] got_end;
      got_status = word[0 +: STATUS_W];
      got_start  = word[OUT_START_LSB +: FIELD_ADDR_W];
      got_end    = word[OUT_END_LSB +: FIELD_ADDR_W];
      if (pending.size() == 0) begin
        report("unexpected result", 64'(word), 64'd0);
      end else begin
        want = pending.pop_front();
        if (got_status !== want.status) report("status", 64'(got_status), 64'(want.status));
        if (got_start !== want.found_start)
          report("found_start", 64'(got_start), 64'(want.found_start));
        if (got_end !== want.found_end) report("found_end", 64'(got_end), 64'(want.found_end));
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // command, region_type, region_start, region_end, page_count (lowest first)
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // status, found_start, found_end (lowest first)
  logic [OUT_TDATA_W-1:0] m_tdata;

  region_table_mirror mirror;
  int                 cycles = 0;
  int                 burst_left = 0;
  int                 rx_mode = 0;
  int                 rx_left = 0;

  address_region_table u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check accepted items, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_result(m_tdata);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Send one command item; hold it until accepted, with gaps between bursts
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [TYPE_W-1:0] rtype,
                       input logic [FIELD_ADDR_W-1:0] rs, input logic [FIELD_ADDR_W-1:0] re,
                       input logic [PAGE_W-1:0] pages);
    region_cmd_t           c;
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    c.cmd        = cmd;
    c.rtype      = rtype;
    c.start_addr = rs;
    c.end_addr   = re;
    c.pages      = pages;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
    end
    burst_left = burst_left - 1;
    word = '0;
    word[IN_CMD_LSB +: CMD_W]          = c.cmd;
    word[IN_TYPE_LSB +: TYPE_W]        = c.rtype;
    word[IN_START_LSB +: FIELD_ADDR_W] = c.start_addr;
    word[IN_END_LSB +: FIELD_ADDR_W]   = c.end_addr;
    word[IN_PAGE_LSB +: PAGE_W]        = c.pages;
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror.apply_command(c);
  endtask

  // Build one random command, biased toward filling or draining the table
  task automatic issue_random(input bit grow);
    logic [CMD_W-1:0]        cmd;
    logic [TYPE_W-1:0]       rtype;
    logic [63:0]             rs;
    logic [63:0]             re;
    logic [PAGE_W-1:0]       pages;
    int                      pick;
    int                      sel;
    pick = $urandom_range(0, 99);
    if (grow) begin
      if (pick < 55) cmd = CMD_INSERT;
      else if (pick < 60) cmd = CMD_REMOVE;
      else if (pick < 66) cmd = CMD_FIND_FIRST;
      else if (pick < 72) cmd = CMD_FIND_LAST;
      else if (pick < 79) cmd = CMD_EXT_END;
      else if (pick < 86) cmd = CMD_EXT_START;
      else if (pick < 93) cmd = CMD_SHRINK_END;
      else cmd = CMD_SHRINK_START;
    end else begin
      if (pick < 15) cmd = CMD_INSERT;
      else if (pick < 50) cmd = CMD_REMOVE;
      else if (pick < 57) cmd = CMD_FIND_FIRST;
      else if (pick < 64) cmd = CMD_FIND_LAST;
      else if (pick < 73) cmd = CMD_EXT_END;
      else if (pick < 82) cmd = CMD_EXT_START;
      else if (pick < 91) cmd = CMD_SHRINK_END;
      else cmd = CMD_SHRINK_START;
    end

    // mostly hit types present in the table
    sel = $urandom_range(0, 9);
    if (mirror.count > 0 && sel < 7) rtype = mirror.rtype[$urandom_range(0, mirror.count - 1)];
    else if (sel < 9) rtype = TYPE_W'($urandom_range(0, 7));
    else rtype = TYPE_W'($urandom);

    // bounds: a small page window so that neighbors meet, plus extremes
    sel = $urandom_range(0, 9);
    if (cmd != CMD_INSERT || sel == 7) begin
      rs = {$urandom, $urandom};
      re = {$urandom, $urandom};
    end else if (sel < 7) begin
      rs = 64'($urandom_range(0, 511)) << PAGE_SHIFT;
      re = rs + (64'($urandom_range(0, 15)) << PAGE_SHIFT);
      if ($urandom_range(0, 7) == 0) re = re + 64'($urandom_range(0, 4095));
    end else if (sel == 8) begin
      re = 64'(ADDR_TOP) - 64'($urandom_range(0, 3));
      rs = re - (64'($urandom_range(0, 31)) << PAGE_SHIFT);
    end else begin
      rs = 64'($urandom_range(0, 2)) << PAGE_SHIFT;
      re = rs + (64'($urandom_range(0, 4)) << PAGE_SHIFT);
      if ($urandom_range(0, 1) == 0) begin
        rs = re + (64'($urandom_range(1, 4)) << PAGE_SHIFT);
      end
    end

    sel = $urandom_range(0, 9);
    if (sel < 6) pages = PAGE_W'($urandom_range(0, 4));
    else if (sel < 8) pages = PAGE_W'($urandom_range(0, 64));
    else if (sel == 8) pages = PAGE_W'($urandom);
    else pages = ($urandom_range(0, 1) == 0) ? '0 : '1;

    issue(cmd, rtype, rs[FIELD_ADDR_W-1:0], re[FIELD_ADDR_W-1:0], pages);
  endtask

  initial begin
    bit grow;
    int phase_left;
    mirror = new();
    grow = 1'b1;
    phase_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, every command, not-found, no-room and shrunk
    issue(CMD_FIND_FIRST, 16'h0000, '0, '0, '0);
    issue(CMD_REMOVE, 16'hFFFF, ADDR_TOP, ADDR_TOP, '1);
    issue(CMD_EXT_END, 16'h0001, '0, '0, 32'd1);
    issue(CMD_INSERT, 16'hFFFF, 48'h1000, 48'h2000, '0);
    issue(CMD_INSERT, 16'h0001, 48'h10000, 48'h20000, '0);
    issue(CMD_INSERT, 16'h0002, 48'hFFFF_FFFF_F000, ADDR_TOP, '0);
    issue(CMD_INSERT, 16'h0000, '0, '0, '0);
    issue(CMD_INSERT, 16'h0001, 48'h40000, 48'h41000, '0);
    issue(CMD_FIND_FIRST, 16'h0001, '0, '0, '0);
    issue(CMD_FIND_LAST, 16'h0001, '0, '0, '0);
    issue(CMD_EXT_END, 16'hFFFF, '0, '0, 32'd1);
    issue(CMD_EXT_END, 16'hFFFF, '0, '0, '1);
    issue(CMD_EXT_END, 16'h0002, '0, '0, 32'd1);
    issue(CMD_EXT_END, 16'h0002, '0, '0, '0);
    issue(CMD_EXT_START, 16'h0001, '0, '0, 32'd1);
    issue(CMD_EXT_START, 16'h0000, '0, '0, 32'd1);
    issue(CMD_EXT_START, 16'h0001, '0, '0, 32'hD);
    issue(CMD_SHRINK_END, 16'h0000, '0, '0, 32'd1);
    issue(CMD_SHRINK_END, 16'h0001, '0, '0, 32'h20);
    issue(CMD_SHRINK_END, 16'h0001, '0, '0, 32'd1);
    issue(CMD_SHRINK_START, 16'h0002, '0, '0, '1);
    issue(CMD_SHRINK_START, 16'h0001, '0, '0, '1);
    issue(CMD_SHRINK_START, 16'h0001, '0, '0, 32'd1);
    issue(CMD_REMOVE, 16'h0001, '0, '0, '0);
    issue(CMD_INSERT, 16'h5A5A, ADDR_TOP, '0, '0);

    // Random: alternate filling and draining phases so the table runs full and empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        grow = !grow;
        phase_left = $urandom_range(40, 120);
      end
      phase_left = phase_left - 1;
      issue_random(grow);
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
